>>> rtl/misg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package misg_pkg;

  localparam int VAL_W    = 32;
  localparam int TOL_W    = 31;
  localparam int SET_W    = 10;
  localparam int COUNT_W  = 11;
  localparam int IDX_W    = 10;
  localparam int SET_LIMIT = 1024;

  typedef enum logic [1:0] {
    CMD_LOAD_DIAG = 2'd0,
    CMD_BEGIN_ROW = 2'd1,
    CMD_ROW_ENTRY = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_SKIP_BELOW = 1'b0,
    REG_MATCH_TOL  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             assigned;
    logic [SET_W-1:0] set_idx;
    logic             orient;
  } info_t;

  // |a - b| < tol, exact
  function automatic logic near_eq(input logic signed [33:0] a,
                                   input logic signed [33:0] b,
                                   input logic [TOL_W-1:0] tol);
    logic signed [34:0] d;
    logic signed [34:0] t;
    d = 35'(a) - 35'(b);
    t = $signed({4'b0, tol});
    return (d < t) && (d > -t);
  endfunction

  // diag - skip + tol > 0
  function automatic logic eligible(input logic signed [VAL_W-1:0] diag,
                                    input logic signed [VAL_W-1:0] skip,
                                    input logic [TOL_W-1:0] tol);
    logic signed [34:0] s;
    s = 35'(diag) - 35'(skip) + $signed({4'b0, tol});
    return s > 0;
  endfunction

endpackage

`default_nettype wire

>>> rtl/minimal_intersection_set_grouper.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake               payload
// in_       input      in_valid / in_stall     command, entity, entry_column, entry_value
// out_      output     out_valid / out_stall   is_member, set_index, orientation, set_count
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one command per cycle while in_stall is low; each command does one read of the
// diagonal and entity memories at accept and at most one write, a diagonal load at accept,
// a row entry in the cycle after. a read result passes stage 1, then the output register.
// after reset a clearing pass wipes every entry of the entity memory;
// in_stall is high during it, configuration writes are taken throughout.
// out_stall holds back the input only while a read result is waiting behind a full
// output register.

module minimal_intersection_set_grouper
  import misg_pkg::*;
#(
  parameter int MAX_ENTITIES = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_command,
  input  wire logic [IDX_W-1:0]        in_entity,
  input  wire logic [IDX_W-1:0]        in_entry_column,
  input  wire logic signed [VAL_W-1:0] in_entry_value,

  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_is_member,
  output logic [SET_W-1:0]             out_set_index,
  output logic                         out_orientation,
  output logic [COUNT_W-1:0]           out_set_count,

  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [VAL_W-1:0]        cfg_data
);

  localparam int AW = $clog2(MAX_ENTITIES);

  // configuration
  logic signed [VAL_W-1:0] skip_below_r;
  logic [TOL_W-1:0]        match_tol_r;

  // memories
  logic signed [VAL_W-1:0] diag_mem [MAX_ENTITIES];
  info_t                   info_mem [MAX_ENTITIES];
  logic signed [VAL_W-1:0] diag_rd_r;
  info_t                   info_rd_r;

  // clearing pass
  logic          clr_active_r;
  logic [AW-1:0] clr_cnt_r;

  // stage 1
  logic                    s1_valid_r;
  cmd_t                    s1_cmd_r;
  logic                    s1_in_range_r;
  logic [AW-1:0]           s1_addr_r;
  logic signed [VAL_W-1:0] s1_val_r;

  // forwarding of the entity write that lands at the accept edge
  logic  fwd_hit_r;
  info_t fwd_data_r;

  // row state
  logic                    row_active_r;
  logic signed [VAL_W-1:0] row_diag_r;
  logic [SET_W-1:0]        row_set_r;
  logic [COUNT_W-1:0]      set_counter_r;

  // output register
  logic               out_valid_r;
  logic               out_member_r;
  logic [SET_W-1:0]   out_set_r;
  logic               out_orient_r;
  logic [COUNT_W-1:0] out_count_r;

  logic                    in_accept;
  cmd_t                    in_cmd;
  logic [16:0]             ent_ext;
  logic [16:0]             col_ext;
  logic [AW-1:0]           rd_addr;
  logic                    rd_in_range;
  info_t                   info_q;
  logic                    row_open;
  logic                    entry_match;
  logic                    begin_row;
  logic                    entry_we;
  logic                    read_go;
  logic                    s1_advance;
  logic                    out_load;
  logic                    info_we;
  logic [AW-1:0]           info_waddr;
  info_t                   info_wdata;
  logic signed [33:0]      diag34;
  logic signed [33:0]      val34;
  logic signed [33:0]      rd34;
  logic signed [33:0]      neg_rd34;
  logic                    elig_q;

  // ---------------- input side ----------------
  assign in_cmd    = cmd_t'(in_command);
  assign in_accept = in_valid && !in_stall;
  assign ent_ext   = {7'b0, in_entity};
  assign col_ext   = {7'b0, in_entry_column};

  always_comb begin
    if (in_cmd == CMD_ROW_ENTRY) begin
      rd_addr     = col_ext[AW-1:0];
      rd_in_range = col_ext < 17'(MAX_ENTITIES);
    end else begin
      rd_addr     = ent_ext[AW-1:0];
      rd_in_range = ent_ext < 17'(MAX_ENTITIES);
    end
  end

  assign in_stall  = clr_active_r || (s1_valid_r && !s1_advance);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_below_r <= '0;
      match_tol_r  <= TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SKIP_BELOW: skip_below_r <= $signed(cfg_data);
        REG_MATCH_TOL:  match_tol_r  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (in_accept && in_cmd == CMD_LOAD_DIAG && rd_in_range) begin
      diag_mem[rd_addr] <= in_entry_value;
    end
    if (in_accept) begin
      diag_rd_r <= diag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    if (in_accept) begin
      info_rd_r <= info_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(MAX_ENTITIES - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
      fwd_hit_r  <= info_we && (info_waddr == rd_addr);
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r      <= in_cmd;
      s1_in_range_r <= rd_in_range;
      s1_addr_r     <= rd_addr;
      s1_val_r      <= in_entry_value;
      fwd_data_r    <= info_wdata;
    end
  end

  assign info_q   = fwd_hit_r ? fwd_data_r : info_rd_r;
  assign diag34   = 34'(diag_rd_r);
  assign val34    = 34'(s1_val_r);
  assign rd34     = 34'(row_diag_r);
  assign neg_rd34 = -rd34;
  assign elig_q   = eligible(diag_rd_r, skip_below_r, match_tol_r);

  assign row_open = s1_in_range_r && (set_counter_r < COUNT_W'(SET_LIMIT)) &&
                    elig_q && !info_q.assigned;

  assign entry_match = row_active_r && s1_in_range_r && elig_q &&
                       near_eq(diag34, rd34, match_tol_r) &&
                       (near_eq(val34, rd34, match_tol_r) ||
                        near_eq(val34, neg_rd34, match_tol_r));

  always_comb begin
    begin_row = 1'b0;
    entry_we  = 1'b0;
    read_go   = 1'b0;
    if (s1_valid_r) begin
      unique case (s1_cmd_r)
        CMD_LOAD_DIAG: ;
        CMD_BEGIN_ROW: begin_row = 1'b1;
        CMD_ROW_ENTRY: entry_we  = entry_match;
        CMD_READ:      read_go   = 1'b1;
        default: ;
      endcase
    end
  end

  assign s1_advance = !(read_go && out_valid_r && out_stall);
  assign out_load   = read_go && s1_advance;

  always_comb begin
    info_we    = clr_active_r || entry_we;
    info_waddr = clr_active_r ? clr_cnt_r : s1_addr_r;
    if (clr_active_r) begin
      info_wdata = '0;
    end else begin
      info_wdata.assigned = 1'b1;
      info_wdata.set_idx  = row_set_r;
      info_wdata.orient   = s1_val_r[VAL_W-1] ^ row_diag_r[VAL_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_active_r  <= 1'b0;
      row_diag_r    <= '0;
      row_set_r     <= '0;
      set_counter_r <= '0;
    end else if (begin_row) begin
      row_active_r <= row_open;
      if (row_open) begin
        row_diag_r    <= diag_rd_r;
        row_set_r     <= set_counter_r[SET_W-1:0];
        set_counter_r <= set_counter_r + COUNT_W'(1);
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_member_r <= s1_in_range_r && info_q.assigned;
      out_set_r    <= (s1_in_range_r && info_q.assigned) ? info_q.set_idx : '0;
      out_orient_r <= s1_in_range_r && info_q.assigned && info_q.orient;
      out_count_r  <= set_counter_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_member   = out_member_r;
  assign out_set_index   = out_set_r;
  assign out_orientation = out_orient_r;
  assign out_set_count   = out_count_r;

  // ---------------- assertions ----------------
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    set_counter_r <= COUNT_W'(SET_LIMIT))
    else $error("set counter beyond limit");

  a_row_set: assert property (@(posedge clk) disable iff (!rst_n)
    row_active_r |-> (row_set_r == SET_W'(set_counter_r - COUNT_W'(1))))
    else $error("open row does not own the last set");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_advance) |=>
      (s1_valid_r && $stable(s1_cmd_r) && $stable(s1_addr_r)))
    else $error("stalled stage 1 lost its command");

  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_hit_r) |-> $past(info_we))
    else $error("forward hit without a write");

endmodule

`default_nettype wire

>>> bench/misg_set_checker.sv
`timescale 1ns / 1ps

module misg_set_checker
  import misg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic [1:0]              in_command,
  input  wire logic [IDX_W-1:0]        in_entity,
  input  wire logic [IDX_W-1:0]        in_entry_column,
  input  wire logic signed [VAL_W-1:0] in_entry_value,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic                    out_is_member,
  input  wire logic [SET_W-1:0]        out_set_index,
  input  wire logic                    out_orientation,
  input  wire logic [COUNT_W-1:0]      out_set_count,
  input  wire logic                    cfg_valid,
  input  wire logic                    cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [VAL_W-1:0]        cfg_data,
  output int                           mismatches,
  output int                           open_reads,
  output int                           reads_checked
);

  typedef struct packed {
    logic               member;
    logic [SET_W-1:0]   set_idx;
    logic               orient;
    logic [COUNT_W-1:0] count;
  } read_answer_t;

  // own copy of the grouping state
  logic signed [VAL_W-1:0] diag_mem [1024];
  logic                    assigned_mem [1024];
  logic [SET_W-1:0]        set_mem [1024];
  logic                    orient_mem [1024];
  logic [COUNT_W-1:0]      sets_formed;
  logic                    row_open;
  logic signed [VAL_W-1:0] row_diag;
  logic [SET_W-1:0]        row_set;
  logic signed [VAL_W-1:0] threshold;
  logic [TOL_W-1:0]        tolerance;

  read_answer_t pending_q [$];
  read_answer_t head;

  function automatic bit within_tol(input longint a, input longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d < longint'(tolerance);
  endfunction

  function automatic bit clears_threshold(input logic signed [VAL_W-1:0] d);
    return longint'(d) - longint'(threshold) + longint'(tolerance) > 0;
  endfunction

  task automatic apply_command(input cmd_t c, input int ent, input int col,
                               input logic signed [VAL_W-1:0] val);
    read_answer_t ans;
    case (c)
      CMD_LOAD_DIAG: begin
        diag_mem[ent] = val;
      end
      CMD_BEGIN_ROW: begin
        row_open = 1'b0;
        if (sets_formed < SET_LIMIT && clears_threshold(diag_mem[ent]) &&
            !assigned_mem[ent]) begin
          row_open    = 1'b1;
          row_diag    = diag_mem[ent];
          row_set     = sets_formed[SET_W-1:0];
          sets_formed = sets_formed + 1'b1;
        end
      end
      CMD_ROW_ENTRY: begin
        if (row_open && clears_threshold(diag_mem[col]) &&
            within_tol(diag_mem[col], row_diag) &&
            (within_tol(val, row_diag) || within_tol(val, -longint'(row_diag)))) begin
          assigned_mem[col] = 1'b1;
          set_mem[col]      = row_set;
          // zero counts as positive on both sides
          orient_mem[col]   = (val < 0) != (row_diag < 0);
        end
      end
      default: begin
        ans.member  = assigned_mem[ent];
        ans.set_idx = ans.member ? set_mem[ent] : '0;
        ans.orient  = ans.member ? orient_mem[ent] : 1'b0;
        ans.count   = sets_formed;
        pending_q.push_back(ans);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold   = '0;
      tolerance   = 1;
      sets_formed = '0;
      row_open    = 1'b0;
      row_diag    = '0;
      row_set     = '0;
      foreach (assigned_mem[i]) assigned_mem[i] = 1'b0;
      pending_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SKIP_BELOW: threshold = cfg_data;
          default:        tolerance = cfg_data[TOL_W-1:0];
        endcase
      end
      if (in_valid && !in_stall)
        apply_command(cmd_t'(in_command), in_entity, in_entry_column, in_entry_value);
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t ns: result beat with no read pending, expected none, actual %0d/%0d/%0d/%0d",
                   $time, out_is_member, out_set_index, out_orientation, out_set_count);
          mismatches++;
        end else begin
          head = pending_q.pop_front();
          check_field("is_member", head.member, out_is_member);
          check_field("set_index", head.set_idx, out_set_index);
          check_field("orientation", head.orient, out_orientation);
          check_field("set_count", head.count, out_set_count);
          reads_checked++;
        end
      end
    end
    open_reads <= pending_q.size();
  end

endmodule

>>> bench/tb_minimal_intersection_set_grouper.sv
`timescale 1ns / 1ps

module tb_minimal_intersection_set_grouper;
  import misg_pkg::*;

  localparam int ONE = 32'h0001_0000;   // 1.0 in Q15.16
  localparam int SPARE_ENTITY = 512;    // kept unassigned; used as a column only once the set counter is full

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_command = 2'b0;
  logic [IDX_W-1:0]        in_entity = '0;
  logic [IDX_W-1:0]        in_entry_column = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_is_member;
  logic [SET_W-1:0]        out_set_index;
  logic                    out_orientation;
  logic [COUNT_W-1:0]      out_set_count;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = 1'b0;
  logic [VAL_W-1:0]        cfg_data = '0;

  int mismatches;
  int open_reads;
  int reads_checked;

  int          send_idle = 0;
  int          recv_idle = 0;
  int unsigned cur_tol = 1;
  int          sent_count = 0;
  int          cfg_writes = 0;
  int          skip_tbl [6];
  int unsigned tol_tbl [6];

  logic signed [VAL_W-1:0] loaded_diag [1024];
  int                      row_pool [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  minimal_intersection_set_grouper uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_entity, .in_entry_column, .in_entry_value,
    .out_valid, .out_stall, .out_is_member, .out_set_index, .out_orientation,
    .out_set_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  misg_set_checker set_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_entity, .in_entry_column, .in_entry_value,
    .out_valid, .out_stall, .out_is_member, .out_set_index, .out_orientation,
    .out_set_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .open_reads, .reads_checked
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic program_regs(input int skip, input int unsigned tol);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SKIP_BELOW;
    cfg_data  <= skip;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_MATCH_TOL;
    cfg_data  <= tol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_tol = tol;
    cfg_writes += 2;
  endtask

  task automatic push_command(input cmd_t c, input int ent, input int col, input int val);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= c;
    in_entity       <= 10'(ent);
    in_entry_column <= 10'(col);
    in_entry_value  <= val;
    if (c == CMD_LOAD_DIAG) loaded_diag[10'(ent)] = val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // all expected reads back, then let trailing memory writes settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_reads != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // a value on the base, just inside or just outside the tolerance, or anything
  function automatic int near_value(input longint base);
    longint off;
    case ($urandom_range(3))
      0: off = 0;
      1: off = (cur_tol > 1) ? longint'($urandom_range(cur_tol - 1, 0)) : 0;
      2: off = longint'(cur_tol) + $urandom_range(3, 0);
      default: return $urandom;
    endcase
    if ($urandom_range(1)) off = -off;
    return 32'(base + off);
  endfunction

  function automatic int pool_pick();
    return row_pool[$urandom_range(row_pool.size() - 1)];
  endfunction

  task automatic random_phase(input int n_items);
    longint grp [3];
    int     stop_at;
    int     e;
    int     c;
    int     k;
    int     roll;
    grp[0] = longint'(int'($urandom) >>> $urandom_range(24, 8));
    grp[1] = -grp[0] + $urandom_range(3, 0);
    case ($urandom_range(2))
      0:       grp[2] = 64'sd2147483647;
      1:       grp[2] = -64'sd2147483648;
      default: grp[2] = 0;
    endcase
    stop_at = sent_count + n_items;
    repeat (12) begin
      e = $urandom_range(1023);
      if (e == SPARE_ENTITY) e = SPARE_ENTITY + 1;
      push_command(CMD_LOAD_DIAG, e, $urandom, near_value(grp[$urandom_range(2)]));
      row_pool.push_back(e);
    end
    while (sent_count < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        // a row: begin then its entries, mostly near the row diagonal
        e = pool_pick();
        push_command(CMD_BEGIN_ROW, e, $urandom, $urandom);
        k = $urandom_range(5);
        repeat (k) begin
          c = pool_pick();
          push_command(CMD_ROW_ENTRY, $urandom, c,
                       near_value($urandom_range(1) ? longint'(loaded_diag[e])
                                                    : -longint'(loaded_diag[e])));
        end
      end else if (roll < 78) begin
        e = ($urandom_range(9) < 7) ? pool_pick() : $urandom_range(1023);
        push_command(CMD_READ, e, $urandom, $urandom);
      end else if (roll < 88) begin
        push_command(CMD_LOAD_DIAG, pool_pick(), $urandom,
                     near_value(grp[$urandom_range(2)]));
      end else begin
        // stray entry, often with no open row
        push_command(CMD_ROW_ENTRY, $urandom, pool_pick(), $urandom);
      end
    end
  endtask

  // keep opening sets on one spare entity until the counter saturates
  task automatic fill_set_counter();
    push_command(CMD_LOAD_DIAG, SPARE_ENTITY, $urandom, 0);
    repeat (1030) begin
      push_command(CMD_BEGIN_ROW, SPARE_ENTITY, $urandom, $urandom);
      if ($urandom_range(39) == 0)
        push_command(CMD_READ, $urandom_range(1023), $urandom, $urandom);
    end
    push_command(CMD_ROW_ENTRY, $urandom, SPARE_ENTITY, 0);
    push_command(CMD_READ, SPARE_ENTITY, $urandom, $urandom);
    push_command(CMD_BEGIN_ROW, pool_pick(), $urandom, $urandom);
    push_command(CMD_ROW_ENTRY, $urandom, pool_pick(), $urandom);
    push_command(CMD_READ, pool_pick(), $urandom, $urandom);
  endtask

  initial begin
    skip_tbl[0] = 0;             tol_tbl[0] = 1;
    skip_tbl[1] = 32'h8000_0000; tol_tbl[1] = 32'h7FFF_FFFF;
    skip_tbl[2] = 32'h7FFF_FFFF; tol_tbl[2] = 0;
    skip_tbl[3] = int'($urandom) >>> 12;
    tol_tbl[3]  = $urandom_range(1 << 16, 1);
    skip_tbl[4] = $urandom;
    tol_tbl[4]  = $urandom_range(32'h7FFF_FFFF);
    skip_tbl[5] = 32'h8000_0000; tol_tbl[5] = 1 << 20;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 23;
    recv_idle = 67;
    program_regs(0, 256);

    // loads, then rows exercising sign, tolerance, eligibility and reassignment
    push_command(CMD_LOAD_DIAG, 0, 1023, ONE);
    push_command(CMD_LOAD_DIAG, 1023, 0, ONE);
    push_command(CMD_LOAD_DIAG, 7, 0, ONE + 100);
    push_command(CMD_LOAD_DIAG, 5, 0, -ONE);
    push_command(CMD_LOAD_DIAG, 9, 0, 32'h7FFF_FFFF);
    push_command(CMD_LOAD_DIAG, 3, 0, ONE);
    push_command(CMD_ROW_ENTRY, 0, 7, ONE);
    push_command(CMD_BEGIN_ROW, 0, 0, 0);
    push_command(CMD_ROW_ENTRY, 0, 1023, -ONE);
    push_command(CMD_ROW_ENTRY, 0, 7, ONE + 50);
    push_command(CMD_ROW_ENTRY, 0, 5, ONE);
    push_command(CMD_ROW_ENTRY, 0, 0, ONE);
    push_command(CMD_READ, 1023, 0, 0);
    push_command(CMD_READ, 5, 0, 0);
    push_command(CMD_BEGIN_ROW, 5, 0, 0);
    push_command(CMD_ROW_ENTRY, 0, 9, 32'h7FFF_FFFF);
    push_command(CMD_BEGIN_ROW, 9, 0, 0);
    push_command(CMD_ROW_ENTRY, 1023, 9, 32'h8000_0000);
    push_command(CMD_BEGIN_ROW, 1023, 0, 0);
    push_command(CMD_BEGIN_ROW, 3, 0, 0);
    push_command(CMD_ROW_ENTRY, 0, 7, -ONE);
    push_command(CMD_READ, 7, 0, 0);
    push_command(CMD_READ, 0, 0, 0);
    push_command(CMD_READ, 9, 0, 0);
    push_command(CMD_READ, SPARE_ENTITY, 1023, -1);
    row_pool = '{0, 1023, 3, 5, 7, 9};

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle = 23;
        recv_idle = 67;
      end else if (p < 4) begin
        send_idle = 67;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      wait_drained();
      program_regs(skip_tbl[p], tol_tbl[p]);
      random_phase(35);
    end
    fill_set_counter();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d commands and %0d checked read beats over %0d register writes",
             sent_count, reads_checked, cfg_writes);
    $display("threshold and tolerance at both extremes, three idling mixes, set counter full");
    if (mismatches == 0 && open_reads == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> minimal_intersection_set_grouper.f
rtl/misg_pkg.sv
rtl/minimal_intersection_set_grouper.sv
bench/misg_set_checker.sv
bench/tb_minimal_intersection_set_grouper.sv
